FILE: design/rrts_pkg.sv
// rrts_pkg: shared constants, command and kind codes, and the queued item type
// for the round-robin thread scheduler. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rrts_pkg;

    localparam int THREAD_SLOTS = 8;
    localparam int TID_W        = $clog2(THREAD_SLOTS);
    localparam int ID_OUT_W     = 3;
    localparam int WAIT_W       = (TID_W > ID_OUT_W) ? TID_W : ID_OUT_W;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int CMD_W        = 3;
    localparam int CYC_W        = 8;
    localparam int QUANT_W      = 16;
    localparam int HOLD_W       = 4;
    localparam int USED_W       = 32;
    localparam int TOTAL_W      = 48;

    // command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_INSTR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CALL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_EXIT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_JOIN   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_YIELD  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd5;

    // classified item kinds
    localparam logic [2:0] KIND_PLAIN  = 3'd0;
    localparam logic [2:0] KIND_EXIT   = 3'd1;
    localparam logic [2:0] KIND_JOIN   = 3'd2;
    localparam logic [2:0] KIND_YIELD  = 3'd3;
    localparam logic [2:0] KIND_CREATE = 3'd4;

    // fixed costs of thread calls
    localparam logic [CYC_W-1:0] COST_EXIT   = 8'd50;
    localparam logic [CYC_W-1:0] COST_JOIN   = 8'd40;
    localparam logic [CYC_W-1:0] COST_YIELD  = 8'd40;
    localparam logic [CYC_W-1:0] COST_CREATE = 8'd80;

    // slot run states
    localparam logic [1:0] RS_READY   = 2'd0;
    localparam logic [1:0] RS_BLOCKED = 2'd1;
    localparam logic [1:0] RS_RUNNING = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF = 1'd1;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd100;
    localparam logic [HOLD_W-1:0]  HOLDOFF_RESET = 4'd6;

    typedef struct packed {
        logic [2:0]        kind;
        logic [CYC_W-1:0]  cost;
        logic              is_call;
        logic [CMD_W-1:0]  target;
        logic              halted;
    } item_t;

endpackage
`default_nettype wire

FILE: design/rrts_front.sv
// rrts_front: accepts input transactions and classifies each command into a
// kind, a base cost and a call flag. Depends on rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrts_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [rrts_pkg::CMD_W-1:0]  s_cmd,
    input  wire logic [rrts_pkg::CYC_W-1:0]  s_cycles,
    input  wire logic [rrts_pkg::CMD_W-1:0]  s_join_target,
    input  wire logic                        s_halted,
    input  wire logic                        q_full,
    output logic                             push,
    output rrts_pkg::item_t                  push_item
);

    logic accepted_reg;
    logic accepted_next;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_item.target  = s_join_target;
        push_item.halted  = s_halted;
        push_item.is_call = 1'b1;
        push_item.cost    = s_cycles;
        push_item.kind    = rrts_pkg::KIND_PLAIN;
        unique case (s_cmd)
            rrts_pkg::CMD_INSTR: begin
                push_item.is_call = 1'b0;
            end
            rrts_pkg::CMD_CALL: begin
                push_item.kind = rrts_pkg::KIND_PLAIN;
            end
            rrts_pkg::CMD_EXIT: begin
                push_item.kind = rrts_pkg::KIND_EXIT;
                push_item.cost = rrts_pkg::COST_EXIT;
            end
            rrts_pkg::CMD_JOIN: begin
                push_item.kind = rrts_pkg::KIND_JOIN;
                push_item.cost = rrts_pkg::COST_JOIN;
            end
            rrts_pkg::CMD_YIELD: begin
                push_item.kind = rrts_pkg::KIND_YIELD;
                push_item.cost = rrts_pkg::COST_YIELD;
            end
            rrts_pkg::CMD_CREATE: begin
                push_item.kind = rrts_pkg::KIND_CREATE;
                push_item.cost = rrts_pkg::COST_CREATE;
            end
            default: begin
                // unused codes behave as plain instructions
                push_item.is_call = 1'b0;
            end
        endcase
    end

    // tracks whether the previous cycle took a transaction
    assign accepted_next = push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accepted_reg <= 1'b0;
        end else begin
            accepted_reg <= accepted_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        accepted_reg |-> $past(s_valid) && !$past(q_full))
        else $error("front took a transaction while the queue was full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push && (s_cmd == rrts_pkg::CMD_INSTR) |-> !push_item.is_call)
        else $error("plain instruction classified as a call");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push && (push_item.kind == rrts_pkg::KIND_CREATE) |-> push_item.is_call)
        else $error("create not classified as a call");

endmodule
`default_nettype wire

FILE: design/rrts_queue.sv
// rrts_queue: short first-in first-out queue of classified items between the
// front and the back end. Depends on rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrts_queue (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  rrts_pkg::item_t push_item,
    output logic            full,
    input  wire logic       pop,
    output logic            q_valid,
    output rrts_pkg::item_t q_item
);

    rrts_pkg::item_t                  entry_reg [rrts_pkg::QUEUE_DEPTH];
    logic [rrts_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [rrts_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [rrts_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             do_push, do_pop;

    localparam logic [rrts_pkg::QPTR_W-1:0] LAST_PTR =
        rrts_pkg::QPTR_W'(rrts_pkg::QUEUE_DEPTH - 1);
    localparam logic [rrts_pkg::QCNT_W-1:0] FULL_CNT =
        rrts_pkg::QCNT_W'(rrts_pkg::QUEUE_DEPTH);

    assign full    = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule
`default_nettype wire

FILE: design/rrts_exec.sv
// rrts_exec: back end holding the thread table, counters and configuration;
// charges each item, then decides on a switch and loads the result register.
// Depends on rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrts_exec (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    input  wire logic [rrts_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  wire logic [rrts_pkg::QUANT_W-1:0]         cfg_wdata,
    input  wire logic                                 q_valid,
    input  rrts_pkg::item_t                           q_item,
    output logic                                      pop,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_switched,
    output logic [rrts_pkg::ID_OUT_W-1:0]             m_from_thread,
    output logic [rrts_pkg::ID_OUT_W-1:0]             m_to_thread,
    output logic                                      m_create_ok,
    output logic [rrts_pkg::ID_OUT_W-1:0]             m_created_id,
    output logic [rrts_pkg::USED_W-1:0]               m_thread_used_cycles,
    output logic [rrts_pkg::TOTAL_W-1:0]              m_total_cycles,
    output logic                                      m_finished
);

    localparam int N     = rrts_pkg::THREAD_SLOTS;
    localparam int TW    = rrts_pkg::TID_W;
    localparam int OW    = rrts_pkg::ID_OUT_W;
    localparam int WW    = rrts_pkg::WAIT_W;
    localparam int QW    = rrts_pkg::QUANT_W;
    localparam int HW    = rrts_pkg::HOLD_W;
    localparam int UW    = rrts_pkg::USED_W;
    localparam int XW    = rrts_pkg::TOTAL_W;
    localparam int CW    = rrts_pkg::CYC_W;

    localparam logic S_EXEC  = 1'b0;
    localparam logic S_SCHED = 1'b1;

    logic                state_reg, state_next;

    logic [QW-1:0]       quantum_cycles_reg;
    logic [HW-1:0]       call_holdoff_reg;

    logic [N-1:0]        alive_reg, alive_next;
    logic [1:0]          rs_reg [N];
    logic [1:0]          rs_next [N];
    logic [WW-1:0]       wait_reg [N];
    logic [WW-1:0]       wait_next [N];
    logic [UW-1:0]       used_reg [N];
    logic [UW-1:0]       used_next [N];
    logic [TW-1:0]       run_reg, run_next;
    logic [QW-1:0]       quant_reg, quant_next;
    logic [HW-1:0]       hold_reg, hold_next;
    logic                yield_reg, yield_next;
    logic [XW-1:0]       total_reg, total_next;

    // item details carried from the charge step to the schedule step
    logic                halted_reg, halted_next;
    logic                create_ok_reg, create_ok_next;
    logic [TW-1:0]       created_reg, created_next;
    logic [UW-1:0]       used_out_reg, used_out_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_switched_reg, m_switched_next;
    logic [OW-1:0]       m_from_reg, m_from_next;
    logic [OW-1:0]       m_to_reg, m_to_next;
    logic                m_create_ok_reg, m_create_ok_next;
    logic [OW-1:0]       m_created_reg, m_created_next;
    logic [UW-1:0]       m_used_reg, m_used_next;
    logic [XW-1:0]       m_total_reg, m_total_next;
    logic                m_finished_reg, m_finished_next;

    logic                free_found;
    logic [TW-1:0]       free_slot;
    logic [CW-1:0]       cost_eff;
    logic [UW:0]         used_sum;
    logic [UW-1:0]       used_sat;
    logic [QW:0]         quant_sum;
    logic [QW-1:0]       quant_sat;
    logic [HW-1:0]       hold_dec;

    logic [N-1:0]        rdy_vec, rdy_hi, rdy_lo, running_vec;
    logic                hi_found, lo_found;
    logic [TW-1:0]       hi_slot, lo_slot, pick;
    logic                due, sw;

    // lowest dead slot other than the running one
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = N - 1; s >= 0; s--) begin
            if (TW'(s) != run_reg && !alive_reg[s]) begin
                free_found = 1'b1;
                free_slot  = TW'(s);
            end
        end
    end

    // round-robin search: first ready slot above the running one, else below
    always_comb begin
        hi_found = 1'b0;
        lo_found = 1'b0;
        hi_slot  = '0;
        lo_slot  = '0;
        for (int s = 0; s < N; s++) begin
            rdy_vec[s]     = alive_reg[s] && (rs_reg[s] == rrts_pkg::RS_READY);
            running_vec[s] = (rs_reg[s] == rrts_pkg::RS_RUNNING);
            rdy_hi[s]      = rdy_vec[s] && (TW'(s) > run_reg);
            rdy_lo[s]      = rdy_vec[s] && (TW'(s) < run_reg);
        end
        for (int s = N - 1; s >= 0; s--) begin
            if (rdy_hi[s]) begin
                hi_found = 1'b1;
                hi_slot  = TW'(s);
            end
            if (rdy_lo[s]) begin
                lo_found = 1'b1;
                lo_slot  = TW'(s);
            end
        end
        pick = hi_found ? hi_slot : (lo_found ? lo_slot : run_reg);
    end

    always_comb begin
        hold_dec  = (hold_reg == '0) ? '0 : hold_reg - 1'b1;
        cost_eff  = (q_item.kind == rrts_pkg::KIND_CREATE && !free_found) ? '0 : q_item.cost;
        used_sum  = {1'b0, used_reg[run_reg]} + (UW + 1)'(cost_eff);
        used_sat  = used_sum[UW] ? '1 : used_sum[UW-1:0];
        quant_sum = {1'b0, quant_reg} + (QW + 1)'(cost_eff);
        quant_sat = quant_sum[QW] ? '1 : quant_sum[QW-1:0];
        due = (hold_reg == '0) && !halted_reg &&
              (yield_reg || (quant_reg >= quantum_cycles_reg) ||
               (rs_reg[run_reg] == rrts_pkg::RS_BLOCKED));
        sw  = due && (pick != run_reg);
    end

    always_comb begin
        state_next       = state_reg;
        alive_next       = alive_reg;
        rs_next          = rs_reg;
        wait_next        = wait_reg;
        used_next        = used_reg;
        run_next         = run_reg;
        quant_next       = quant_reg;
        hold_next        = hold_reg;
        yield_next       = yield_reg;
        total_next       = total_reg;
        halted_next      = halted_reg;
        create_ok_next   = create_ok_reg;
        created_next     = created_reg;
        used_out_next    = used_out_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_switched_next  = m_switched_reg;
        m_from_next      = m_from_reg;
        m_to_next        = m_to_reg;
        m_create_ok_next = m_create_ok_reg;
        m_created_next   = m_created_reg;
        m_used_next      = m_used_reg;
        m_total_next     = m_total_reg;
        m_finished_next  = m_finished_reg;
        pop              = 1'b0;

        unique case (state_reg)
            S_EXEC: begin
                if (q_valid) begin
                    pop                = 1'b1;
                    state_next         = S_SCHED;
                    hold_next          = q_item.is_call ? call_holdoff_reg : hold_dec;
                    used_next[run_reg] = used_sat;
                    used_out_next      = used_sat;
                    quant_next         = quant_sat;
                    total_next         = total_reg + XW'(cost_eff);
                    halted_next        = q_item.halted;
                    create_ok_next     = 1'b0;
                    created_next       = '0;
                    unique case (q_item.kind)
                        rrts_pkg::KIND_EXIT: begin
                            alive_next[run_reg] = 1'b0;
                            // wake everyone joined on the exiting thread
                            for (int s = 0; s < N; s++) begin
                                if (TW'(s) != run_reg &&
                                    rs_reg[s] == rrts_pkg::RS_BLOCKED &&
                                    wait_reg[s] == WW'(run_reg)) begin
                                    rs_next[s] = rrts_pkg::RS_READY;
                                end
                            end
                        end
                        rrts_pkg::KIND_JOIN: begin
                            rs_next[run_reg]   = rrts_pkg::RS_BLOCKED;
                            wait_next[run_reg] = WW'(q_item.target);
                        end
                        rrts_pkg::KIND_YIELD: begin
                            yield_next = 1'b1;
                        end
                        rrts_pkg::KIND_CREATE: begin
                            if (free_found) begin
                                alive_next[free_slot] = 1'b1;
                                rs_next[free_slot]    = rrts_pkg::RS_READY;
                                used_next[free_slot]  = '0;
                                create_ok_next        = 1'b1;
                                created_next          = free_slot;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCHED: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_EXEC;
                    if (due) begin
                        quant_next = '0;
                        yield_next = 1'b0;
                    end
                    if (sw) begin
                        if (rs_reg[run_reg] != rrts_pkg::RS_BLOCKED) begin
                            rs_next[run_reg] = rrts_pkg::RS_READY;
                        end
                        rs_next[pick] = rrts_pkg::RS_RUNNING;
                        run_next      = pick;
                    end
                    m_valid_next     = 1'b1;
                    m_switched_next  = sw;
                    m_from_next      = OW'(run_reg);
                    m_to_next        = OW'(sw ? pick : run_reg);
                    m_create_ok_next = create_ok_reg;
                    m_created_next   = OW'(created_reg);
                    m_used_next      = used_out_reg;
                    m_total_next     = total_reg;
                    m_finished_next  = halted_reg && !sw;
                end
            end
            default: begin
                state_next = S_EXEC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_EXEC;
            quantum_cycles_reg <= rrts_pkg::QUANTUM_RESET;
            call_holdoff_reg   <= rrts_pkg::HOLDOFF_RESET;
            alive_reg          <= N'(1);
            for (int s = 0; s < N; s++) begin
                rs_reg[s]   <= (s == 0) ? rrts_pkg::RS_RUNNING : rrts_pkg::RS_READY;
                wait_reg[s] <= '0;
                used_reg[s] <= '0;
            end
            run_reg     <= '0;
            quant_reg   <= '0;
            hold_reg    <= '0;
            yield_reg   <= 1'b0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            alive_reg   <= alive_next;
            rs_reg      <= rs_next;
            wait_reg    <= wait_next;
            used_reg    <= used_next;
            run_reg     <= run_next;
            quant_reg   <= quant_next;
            hold_reg    <= hold_next;
            yield_reg   <= yield_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_addr)
                    rrts_pkg::REG_QUANTUM: quantum_cycles_reg <= cfg_wdata;
                    rrts_pkg::REG_HOLDOFF: call_holdoff_reg   <= cfg_wdata[HW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        halted_reg      <= halted_next;
        create_ok_reg   <= create_ok_next;
        created_reg     <= created_next;
        used_out_reg    <= used_out_next;
        m_switched_reg  <= m_switched_next;
        m_from_reg      <= m_from_next;
        m_to_reg        <= m_to_next;
        m_create_ok_reg <= m_create_ok_next;
        m_created_reg   <= m_created_next;
        m_used_reg      <= m_used_next;
        m_total_reg     <= m_total_next;
        m_finished_reg  <= m_finished_next;
    end

    assign m_valid              = m_valid_reg;
    assign m_switched           = m_switched_reg;
    assign m_from_thread        = m_from_reg;
    assign m_to_thread          = m_to_reg;
    assign m_create_ok          = m_create_ok_reg;
    assign m_created_id         = m_created_reg;
    assign m_thread_used_cycles = m_used_reg;
    assign m_total_cycles       = m_total_reg;
    assign m_finished           = m_finished_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        rs_reg[run_reg] != rrts_pkg::RS_READY)
        else $error("running thread marked ready");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(running_vec) <= 1)
        else $error("more than one slot marked running");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_switched_reg |-> m_from_reg != m_to_reg)
        else $error("switch reported to the same thread");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> state_reg == S_SCHED)
        else $error("item taken without a schedule step");

endmodule
`default_nettype wire

FILE: design/round_robin_thread_scheduler.sv
// round_robin_thread_scheduler: top level joining the classifying front, the
// item queue and the scheduling back end. Depends on rrts_pkg and those modules.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted transaction is one retired instruction or thread call and gives
// exactly one result. The back end charges an item's cost and updates the
// thread table in S_EXEC, then runs the round-robin search and loads the result
// register in S_SCHED, which waits while an earlier result is not yet taken on
// m_ready; it takes no new item until the result of the last one is loaded.
// A two-entry queue lets the input keep taking transactions while a result
// waits on m_ready. The configuration port is always ready and must only be
// written while no item is in flight.
module round_robin_thread_scheduler (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rrts_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [rrts_pkg::QUANT_W-1:0]      cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [rrts_pkg::CMD_W-1:0]        s_cmd,
    input  wire logic [rrts_pkg::CYC_W-1:0]        s_cycles,
    input  wire logic [rrts_pkg::CMD_W-1:0]        s_join_target,
    input  wire logic                              s_halted,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_switched,
    output logic [rrts_pkg::ID_OUT_W-1:0]          m_from_thread,
    output logic [rrts_pkg::ID_OUT_W-1:0]          m_to_thread,
    output logic                                   m_create_ok,
    output logic [rrts_pkg::ID_OUT_W-1:0]          m_created_id,
    output logic [rrts_pkg::USED_W-1:0]            m_thread_used_cycles,
    output logic [rrts_pkg::TOTAL_W-1:0]           m_total_cycles,
    output logic                                   m_finished
);

    logic            push, q_full, q_valid, pop;
    rrts_pkg::item_t push_item, q_item;

    assign cfg_ready = 1'b1;

    rrts_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_cycles      (s_cycles),
        .s_join_target (s_join_target),
        .s_halted      (s_halted),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    rrts_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    rrts_exec u_exec (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_addr             (cfg_addr),
        .cfg_wdata            (cfg_wdata),
        .q_valid              (q_valid),
        .q_item               (q_item),
        .pop                  (pop),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_switched           (m_switched),
        .m_from_thread        (m_from_thread),
        .m_to_thread          (m_to_thread),
        .m_create_ok          (m_create_ok),
        .m_created_id         (m_created_id),
        .m_thread_used_cycles (m_thread_used_cycles),
        .m_total_cycles       (m_total_cycles),
        .m_finished           (m_finished)
    );

endmodule
`default_nettype wire

FILE: dv/tb.sv
// tb: self-checking bench for round_robin_thread_scheduler, with a directed table followed by
// random phases under several register settings, checked against expected values given in
// the table or else an in-bench scheduler model. Depends on rrts_pkg and the design files.
`timescale 1ns / 1ps
module tb;
    import rrts_pkg::*;

    localparam int WATCHDOG_LIMIT     = 2000;
    localparam int DIRECTED_ROWS      = 26;
    localparam int HOLDOFF_OFF_ROW    = 18;
    localparam int RANDOM_PHASE_ITEMS = 70;
    localparam int SATURATION_ITEMS   = 268;
    localparam int QUANTUM_CEILING    = 65535;

    // codes 6 and 7 are not thread calls and behave as plain instructions
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [CYC_W-1:0] cyc;
        logic [CMD_W-1:0] tgt;
        logic             halt;
    } sched_item_t;

    typedef struct packed {
        logic                switched;
        logic [ID_OUT_W-1:0] from_thread;
        logic [ID_OUT_W-1:0] to_thread;
        logic                create_ok;
        logic [ID_OUT_W-1:0] created_id;
        logic [USED_W-1:0]   used_cycles;
        logic [TOTAL_W-1:0]  total_cycles;
        logic                finished;
    } sched_result_t;

    typedef struct packed {
        sched_item_t   item;
        logic          typed;
        sched_result_t want;
    } sched_stim_t;

    localparam sched_result_t NO_RESULT = '0;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [QUANT_W-1:0]    cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd = '0;
    logic [CYC_W-1:0]      s_cycles = '0;
    logic [CMD_W-1:0]      s_join_target = '0;
    logic                  s_halted = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_switched;
    logic [ID_OUT_W-1:0]   m_from_thread;
    logic [ID_OUT_W-1:0]   m_to_thread;
    logic                  m_create_ok;
    logic [ID_OUT_W-1:0]   m_created_id;
    logic [USED_W-1:0]     m_thread_used_cycles;
    logic [TOTAL_W-1:0]    m_total_cycles;
    logic                  m_finished;

    // scheduler model state
    logic                  slot_live   [THREAD_SLOTS];
    logic [1:0]            slot_state  [THREAD_SLOTS];
    logic [TID_W-1:0]      slot_waits  [THREAD_SLOTS];
    logic [USED_W-1:0]     slot_cycles [THREAD_SLOTS];
    logic [TID_W-1:0]      cur_thread;
    int unsigned           quantum_acc;
    logic [HOLD_W-1:0]     holdoff_left;
    logic                  yield_req;
    logic [TOTAL_W-1:0]    cycles_sum;
    logic [QUANT_W-1:0]    quantum_limit;
    logic [HOLD_W-1:0]     holdoff_len;

    sched_stim_t           stimulus_q [$];
    sched_result_t         expected_results [$];
    sched_stim_t           in_flight = '0;
    sched_stim_t           next_row;
    sched_result_t         result_want;
    sched_result_t         item_prediction;
    int                    gap_pct = 0;
    int                    stall_pct = 0;
    int                    mismatches = 0;
    int                    results_seen = 0;
    int                    quiet_cycles = 0;

    sched_stim_t directed_rows [DIRECTED_ROWS] = '{
        // lone thread overruns its quantum with nobody else ready
        {CMD_INSTR,  8'd255, 3'd0, 1'b0, 1'b1,
         {1'b0, 3'd0, 3'd0, 1'b0, 3'd0, 32'd255, 48'd255, 1'b0}},
        {CMD_INSTR,  8'd0,   3'd7, 1'b1, 1'b1,
         {1'b0, 3'd0, 3'd0, 1'b0, 3'd0, 32'd255, 48'd255, 1'b1}},
        {CMD_CREATE, 8'd255, 3'd0, 1'b0, 1'b1,
         {1'b0, 3'd0, 3'd0, 1'b1, 3'd1, 32'd335, 48'd335, 1'b0}},
        {CMD_CREATE, 8'hAA,  3'd1, 1'b0, 1'b0, NO_RESULT},
        {CMD_CREATE, 8'h55,  3'd2, 1'b0, 1'b0, NO_RESULT},
        {CMD_CREATE, 8'd0,   3'd3, 1'b0, 1'b0, NO_RESULT},
        {CMD_CREATE, 8'd1,   3'd4, 1'b0, 1'b0, NO_RESULT},
        {CMD_CREATE, 8'd128, 3'd5, 1'b0, 1'b0, NO_RESULT},
        {CMD_CREATE, 8'd7,   3'd6, 1'b0, 1'b0, NO_RESULT},
        // table full
        {CMD_CREATE, 8'd0,   3'd0, 1'b0, 1'b1,
         {1'b0, 3'd0, 3'd0, 1'b0, 3'd0, 32'd815, 48'd815, 1'b0}},
        {CMD_YIELD,  8'd0,   3'd7, 1'b0, 1'b0, NO_RESULT},
        {CMD_CALL,   8'd200, 3'd0, 1'b0, 1'b0, NO_RESULT},
        {CMD_RSVD6,  8'd0,   3'd0, 1'b0, 1'b0, NO_RESULT},
        {CMD_RSVD7,  8'd1,   3'd0, 1'b0, 1'b0, NO_RESULT},
        {CMD_INSTR,  8'd1,   3'd0, 1'b1, 1'b0, NO_RESULT},
        {CMD_INSTR,  8'd128, 3'd0, 1'b0, 1'b0, NO_RESULT},
        {CMD_INSTR,  8'd0,   3'd0, 1'b1, 1'b0, NO_RESULT},
        // hold-off just expired but halted, so the pending yield waits
        {CMD_INSTR,  8'd17,  3'd0, 1'b1, 1'b0, NO_RESULT},
        {CMD_INSTR,  8'd64,  3'd0, 1'b0, 1'b0, NO_RESULT},
        {CMD_JOIN,   8'd0,   3'd2, 1'b0, 1'b0, NO_RESULT},
        {CMD_JOIN,   8'd0,   3'd5, 1'b0, 1'b0, NO_RESULT},
        {CMD_YIELD,  8'd0,   3'd0, 1'b0, 1'b0, NO_RESULT},
        {CMD_JOIN,   8'd0,   3'd4, 1'b0, 1'b0, NO_RESULT},
        {CMD_EXIT,   8'd0,   3'd0, 1'b0, 1'b0, NO_RESULT},
        {CMD_YIELD,  8'd0,   3'd0, 1'b0, 1'b0, NO_RESULT},
        {CMD_JOIN,   8'd0,   3'd5, 1'b0, 1'b0, NO_RESULT}
    };

    round_robin_thread_scheduler dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_addr             (cfg_addr),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_cmd                (s_cmd),
        .s_cycles             (s_cycles),
        .s_join_target        (s_join_target),
        .s_halted             (s_halted),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_switched           (m_switched),
        .m_from_thread        (m_from_thread),
        .m_to_thread          (m_to_thread),
        .m_create_ok          (m_create_ok),
        .m_created_id         (m_created_id),
        .m_thread_used_cycles (m_thread_used_cycles),
        .m_total_cycles       (m_total_cycles),
        .m_finished           (m_finished)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic clear_schedule();
        for (int s = 0; s < THREAD_SLOTS; s++) begin
            slot_live[s]   = 1'b0;
            slot_state[s]  = RS_READY;
            slot_waits[s]  = '0;
            slot_cycles[s] = '0;
        end
        slot_live[0]  = 1'b1;
        slot_state[0] = RS_RUNNING;
        cur_thread    = '0;
        quantum_acc   = 0;
        holdoff_left  = '0;
        yield_req     = 1'b0;
        cycles_sum    = '0;
        quantum_limit = QUANTUM_RESET;
        holdoff_len   = HOLDOFF_RESET;
    endtask

    function automatic sched_result_t schedule_item(sched_item_t it);
        sched_result_t     r;
        int unsigned       cost;
        logic [USED_W:0]   used_sum;
        logic [TID_W-1:0]  cand;
        logic              found;
        int                s;
        int                idx;
        r = '0;
        cost = 0;
        found = 1'b0;
        r.from_thread = cur_thread;
        if (holdoff_left != 0)
            holdoff_left = holdoff_left - 1'b1;
        case (it.cmd)
            CMD_CALL: cost = 32'(it.cyc);
            CMD_EXIT: begin
                slot_live[cur_thread] = 1'b0;
                for (s = 0; s < THREAD_SLOTS; s++)
                    if (s != cur_thread && slot_state[s] == RS_BLOCKED
                        && slot_waits[s] == cur_thread)
                        slot_state[s] = RS_READY;
                cost = 32'(COST_EXIT);
            end
            CMD_JOIN: begin
                slot_state[cur_thread] = RS_BLOCKED;
                slot_waits[cur_thread] = it.tgt;
                cost = 32'(COST_JOIN);
            end
            CMD_YIELD: begin
                yield_req = 1'b1;
                cost = 32'(COST_YIELD);
            end
            CMD_CREATE: begin
                // lowest dead slot, never the running one even when it has exited
                for (s = 0; s < THREAD_SLOTS; s++)
                    if (!found && s != cur_thread && !slot_live[s]) begin
                        found = 1'b1;
                        r.created_id = ID_OUT_W'(s);
                    end
                if (found) begin
                    r.create_ok = 1'b1;
                    slot_live[r.created_id]   = 1'b1;
                    slot_state[r.created_id]  = RS_READY;
                    slot_cycles[r.created_id] = '0;
                    cost = 32'(COST_CREATE);
                end
            end
            default: cost = 32'(it.cyc);
        endcase
        if (it.cmd >= CMD_CALL && it.cmd <= CMD_CREATE)
            holdoff_left = holdoff_len;

        used_sum = {1'b0, slot_cycles[cur_thread]} + (USED_W + 1)'(cost);
        slot_cycles[cur_thread] = used_sum[USED_W] ? '1 : used_sum[USED_W-1:0];
        quantum_acc = quantum_acc + cost;
        if (quantum_acc > QUANTUM_CEILING)
            quantum_acc = QUANTUM_CEILING;
        cycles_sum = cycles_sum + TOTAL_W'(cost);

        if (holdoff_left == 0 && !it.halt && (yield_req || quantum_acc >= quantum_limit
            || slot_state[cur_thread] == RS_BLOCKED)) begin
            quantum_acc = 0;
            cand = cur_thread;
            found = 1'b0;
            for (s = 1; s < THREAD_SLOTS; s++) begin
                idx = (cur_thread + s) % THREAD_SLOTS;
                if (!found && slot_live[idx] && slot_state[idx] == RS_READY) begin
                    found = 1'b1;
                    cand = TID_W'(idx);
                end
            end
            if (cand != cur_thread) begin
                if (slot_state[cur_thread] != RS_BLOCKED)
                    slot_state[cur_thread] = RS_READY;
                slot_state[cand] = RS_RUNNING;
                cur_thread = cand;
                r.switched = 1'b1;
            end
            yield_req = 1'b0;
        end

        r.to_thread    = cur_thread;
        r.used_cycles  = slot_cycles[r.from_thread];
        r.total_cycles = cycles_sum;
        r.finished     = it.halt && !r.switched;
        return r;
    endfunction

    function automatic sched_stim_t random_stim();
        sched_stim_t r;
        int unsigned pick;
        r = '0;
        pick = $urandom_range(99);
        if (pick < 35)
            r.item.cmd = CMD_INSTR;
        else if (pick < 50)
            r.item.cmd = CMD_CALL;
        else if (pick < 58)
            r.item.cmd = CMD_EXIT;
        else if (pick < 68)
            r.item.cmd = CMD_JOIN;
        else if (pick < 78)
            r.item.cmd = CMD_YIELD;
        else if (pick < 92)
            r.item.cmd = CMD_CREATE;
        else if (pick < 96)
            r.item.cmd = CMD_RSVD6;
        else
            r.item.cmd = CMD_RSVD7;
        pick = $urandom_range(9);
        if (pick == 0)
            r.item.cyc = '0;
        else if (pick == 1)
            r.item.cyc = '1;
        else
            r.item.cyc = CYC_W'($urandom_range(255));
        r.item.tgt  = CMD_W'($urandom_range(7));
        r.item.halt = ($urandom_range(99) < 8);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: mismatch on result %0d: %s", $time, results_seen, what);
        mismatches++;
    endtask

    task automatic compare_field(string name, logic [TOTAL_W-1:0] got,
                                 logic [TOTAL_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // wait for the block to drain, then let its pipeline settle
    task automatic wait_idle();
        do @(negedge aclk);
        while (stimulus_q.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [QUANT_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_QUANTUM)
            quantum_limit = value;
        else
            holdoff_len = value[HOLD_W-1:0];
        @(negedge aclk);
    endtask

    task automatic run_phase(logic [QUANT_W-1:0] quantum, logic [HOLD_W-1:0] holdoff,
                             int gap, int stall, int n);
        logic [QUANT_W-1:0] hold_word;
        wait_idle();
        // upper bits of the hold-off write are junk and must be dropped
        hold_word = QUANT_W'($urandom);
        hold_word[HOLD_W-1:0] = holdoff;
        write_reg(REG_QUANTUM, quantum);
        write_reg(REG_HOLDOFF, hold_word);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (n) stimulus_q.push_back(random_stim());
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (stimulus_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                next_row = stimulus_q.pop_front();
                s_valid       <= 1'b1;
                s_cmd         <= next_row.item.cmd;
                s_cycles      <= next_row.item.cyc;
                s_join_target <= next_row.item.tgt;
                s_halted      <= next_row.item.halt;
                in_flight     <= next_row;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no transaction outstanding");
                end else begin
                    result_want = expected_results.pop_front();
                    compare_field("switched", TOTAL_W'(m_switched),
                                  TOTAL_W'(result_want.switched));
                    compare_field("from_thread", TOTAL_W'(m_from_thread),
                                  TOTAL_W'(result_want.from_thread));
                    compare_field("to_thread", TOTAL_W'(m_to_thread),
                                  TOTAL_W'(result_want.to_thread));
                    compare_field("create_ok", TOTAL_W'(m_create_ok),
                                  TOTAL_W'(result_want.create_ok));
                    compare_field("created_id", TOTAL_W'(m_created_id),
                                  TOTAL_W'(result_want.created_id));
                    compare_field("thread_used_cycles", TOTAL_W'(m_thread_used_cycles),
                                  TOTAL_W'(result_want.used_cycles));
                    compare_field("total_cycles", m_total_cycles, result_want.total_cycles);
                    compare_field("finished", TOTAL_W'(m_finished),
                                  TOTAL_W'(result_want.finished));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                // the model runs on every transaction so its state stays in step
                item_prediction = schedule_item(in_flight.item);
                expected_results.push_back(in_flight.typed ? in_flight.want : item_prediction);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        sched_stim_t sat_row;
        clear_schedule();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table, reset register values first, then no hold-off
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (i == HOLDOFF_OFF_ROW) begin
                wait_idle();
                write_reg(REG_HOLDOFF, '0);
            end
            stimulus_q.push_back(directed_rows[i]);
        end

        run_phase(16'd1, 4'd0, 0, 0, RANDOM_PHASE_ITEMS);
        run_phase(16'hFFFF, 4'd15, 54, 0, RANDOM_PHASE_ITEMS);
        run_phase(16'd0, 4'd3, 0, 54, RANDOM_PHASE_ITEMS);
        run_phase(16'($urandom_range(300, 40)), 4'($urandom_range(15)), 38, 38,
                  RANDOM_PHASE_ITEMS);
        run_phase(16'($urandom_range(200, 20)), 4'd1, 38, 38, RANDOM_PHASE_ITEMS);

        // long halted stretch drives the quantum counter into saturation
        run_phase(16'hFFFF, 4'd2, 0, 0, 0);
        sat_row = '0;
        sat_row.item.cmd = CMD_CREATE;
        stimulus_q.push_back(sat_row);
        repeat (SATURATION_ITEMS) begin
            sat_row = '0;
            sat_row.item.cmd  = CMD_INSTR;
            sat_row.item.cyc  = CYC_W'($urandom_range(255, 248));
            sat_row.item.tgt  = CMD_W'($urandom_range(7));
            sat_row.item.halt = 1'b1;
            stimulus_q.push_back(sat_row);
        end
        repeat (12) stimulus_q.push_back(random_stim());

        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
